FILE: design/cct_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the closed contour tracer
// no dependencies; imported by every module of the block except cct_ram
package cct_pkg;

  // default image bounds
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // register reset values
  localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [7:0] RST_DARK_LEVEL   = 8'd10;
  localparam logic [7:0] RST_SAMPLE_STEP  = 8'd50;

  // walk constants
  localparam logic [3:0] TRIES_MAX   = 4'd9;
  localparam logic [2:0] START_DIR   = 3'd2;
  localparam logic [2:0] REVERSE_OFS = 3'd5;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_DARK_LEVEL   = 2'd2,
    REG_SAMPLE_STEP  = 2'd3
  } cct_reg_t;

  // commands
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TRACE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cct_cmd_t;

  // result status codes
  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_FOUND  = 3'd1;
  localparam logic [2:0] ST_NONE   = 3'd2;
  localparam logic [2:0] ST_DOT    = 3'd3;
  localparam logic [2:0] ST_BEYOND = 3'd4;

  // neighbour classification from the step unit
  typedef struct packed {
    logic at_start;
    logic in_image;
  } cct_nbr_t;

  // column offset of a direction (N, NE, E, SE, S, SW, W, NW), 2'b11 is -1
  function automatic logic [1:0] step_dx(input logic [2:0] dir);
    logic [1:0] d;
    unique case (dir)
      3'd0, 3'd4: d = 2'b00;
      3'd1, 3'd2, 3'd3: d = 2'b01;
      default: d = 2'b11;
    endcase
    return d;
  endfunction

  // row offset of a direction
  function automatic logic [1:0] step_dy(input logic [2:0] dir);
    logic [1:0] d;
    unique case (dir)
      3'd2, 3'd6: d = 2'b00;
      3'd3, 3'd4, 3'd5: d = 2'b01;
      default: d = 2'b11;
    endcase
    return d;
  endfunction

endpackage

FILE: design/cct_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module cct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cct_step_unit.sv
`timescale 1ns / 1ps
// neighbour step unit: next position for one direction and its class
// depends on cct_pkg for the direction tables and cct_nbr_t
module cct_step_unit import cct_pkg::*; #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic [XW-1:0] cur_x,
  input  logic [YW-1:0] cur_y,
  input  logic [2:0]    dir,
  input  logic [XW-1:0] start_x,
  input  logic [YW-1:0] start_y,
  input  logic [XW:0]   width,
  input  logic [YW:0]   height,
  output logic [XW:0]   nx,
  output logic [YW:0]   ny,
  output cct_nbr_t      nbr
);

  logic [1:0] dx;
  logic [1:0] dy;

  // offsets wrap to all ones below zero, which is never in the image
  always_comb begin
    dx = step_dx(dir);
    dy = step_dy(dir);
    nx = {1'b0, cur_x} + {{(XW - 1){dx[1]}}, dx};
    ny = {1'b0, cur_y} + {{(YW - 1){dy[1]}}, dy};
    nbr.at_start = (nx == {1'b0, start_x}) && (ny == {1'b0, start_y});
    nbr.in_image = (nx < width) && (ny < height);
  end

endmodule

FILE: design/closed_contour_tracer_core.sv
`timescale 1ns / 1ps
// top level of the closed contour tracer: sequencer, maps and path stack
// depends on cct_pkg, cct_ram and cct_step_unit
//
// channel   signals                                       role
// cfg       cfg_we, cfg_index, cfg_data                   register write
// in        in_valid, in_stall, cmd, chan_*, dot_number   command transaction
// out       out_valid, out_stall, status, path_length,    result transaction
//           dot_x, dot_y
//
// load: after a width write, a restoring divide first places the load position in
//   the new raster; a load past the image and a nop go straight to the result
// trace: a clearing pass over the visited map, then the walk: each direction is
//   tried through the one step unit, one in the image also reads the single read
//   port of each map, and a pop reads the path stack
// read: multiply, compare, stack read and result for a dot; no stack read beyond
// reset clears control state; map and stack contents are not cleared
// in_stall is high while a command runs; a result waits in the output
//   register and the next command is taken meanwhile
module closed_contour_tracer_core import cct_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  chan_blue,
  input  logic [7:0]  chan_green,
  input  logic [7:0]  chan_red,
  input  logic [15:0] dot_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [16:0] path_length,
  output logic [7:0]  dot_x,
  output logic [7:0]  dot_y
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int MW    = XW + YW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = $clog2(CELLS + 1);
  localparam int SW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int EW    = XW + YW + 7;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIV, S_CLR, S_TRY, S_CHECK, S_POP, S_POPW,
    S_RMUL, S_RCHK, S_RDATA, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0] image_width;
  logic [8:0] image_height;
  logic [7:0] dark_level;
  logic [7:0] sample_step;

  // control state
  logic [PW-1:0] load_pos;
  logic [XW-1:0] load_x;
  logic [YW-1:0] load_y;
  logic          xy_ok;
  logic [XW-1:0] start_x;
  logic [YW-1:0] start_y;
  logic          start_known;
  logic [LW-1:0] level;
  logic [MW-1:0] cnt;

  // walk registers
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic [2:0]    dir;
  logic [3:0]    tries;
  logic [XW:0]   nx_q;
  logic [YW:0]   ny_q;

  // divide registers
  logic [XW-1:0] rem;
  logic [PW-1:0] quo;

  // captured command fields and read product
  logic [7:0]  blue_q;
  logic [7:0]  green_q;
  logic [7:0]  red_q;
  logic [15:0] dot_q;
  logic [23:0] prod;

  // pending result
  logic [2:0]    res_status;
  logic [XW-1:0] res_x;
  logic [YW-1:0] res_y;

  // clamped dimensions
  logic [XW:0]   w_cl;
  logic [YW:0]   h_cl;
  logic [PW-1:0] area;

  always_comb begin
    if (image_width == 9'd0) begin
      w_cl = (XW + 1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_cl = (XW + 1)'(MAX_WIDTH);
    end else begin
      w_cl = (XW + 1)'(image_width);
    end
    if (image_height == 9'd0) begin
      h_cl = (YW + 1)'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_cl = (YW + 1)'(MAX_HEIGHT);
    end else begin
      h_cl = (YW + 1)'(image_height);
    end
    area = PW'(w_cl) * PW'(h_cl);
  end

  // neighbour of the current pixel
  logic [XW:0] nx;
  logic [YW:0] ny;
  cct_nbr_t    nbr;

  cct_step_unit #(.XW(XW), .YW(YW)) u_step (
    .cur_x   (cur_x),
    .cur_y   (cur_y),
    .dir     (dir),
    .start_x (start_x),
    .start_y (start_y),
    .width   (w_cl),
    .height  (h_cl),
    .nx      (nx),
    .ny      (ny),
    .nbr     (nbr)
  );

  // map and stack port control
  logic          edge_we;
  logic          edge_q;
  logic          vis_we;
  logic [MW-1:0] vis_waddr;
  logic          vis_wdata;
  logic          vis_q;
  logic [MW-1:0] nbr_addr;
  logic          push_ok;
  logic          stk_we;
  logic [SW-1:0] stk_raddr;
  logic [EW-1:0] stk_wdata;
  logic [EW-1:0] stk_q;
  logic          is_edge;
  logic [XW:0]   trial;
  logic [XW-1:0] ld_x;
  logic [YW-1:0] ld_y;
  logic          fin_fire;

  always_comb begin
    is_edge   = (blue_q < dark_level) && (green_q < dark_level) && (red_q < dark_level);
    nbr_addr  = {ny[YW-1:0], nx[XW-1:0]};
    push_ok   = edge_q && !vis_q && (32'(level) < CELLS);
    edge_we   = (state == S_LOAD);
    stk_we    = (state == S_CHECK) && push_ok;
    stk_wdata = {cur_x, cur_y, dir + 3'd1, tries + 4'd1};
    stk_raddr = (state == S_POP) ? SW'(level - LW'(1)) : prod[SW-1:0];
    trial     = {rem, quo[PW-1]};
    ld_x      = xy_ok ? load_x : rem;
    ld_y      = xy_ok ? load_y : quo[YW-1:0];
    fin_fire  = (state == S_FIN) && (!out_valid || !out_stall);
    if (state == S_CLR) begin
      vis_we    = 1'b1;
      vis_waddr = cnt;
      vis_wdata = 1'b0;
    end else begin
      vis_we    = stk_we;
      vis_waddr = {ny_q[YW-1:0], nx_q[XW-1:0]};
      vis_wdata = 1'b1;
    end
  end

  cct_ram #(.WIDTH(1), .DEPTH(2 ** MW)) u_edge_map (
    .clk   (clk),
    .we    (edge_we),
    .waddr ({ld_y, ld_x}),
    .wdata (is_edge),
    .raddr (nbr_addr),
    .rdata (edge_q)
  );

  cct_ram #(.WIDTH(1), .DEPTH(2 ** MW)) u_visited_map (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (nbr_addr),
    .rdata (vis_q)
  );

  cct_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_path_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (level[SW-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  assign in_stall = (state != S_IDLE);

  // sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      dark_level   <= RST_DARK_LEVEL;
      sample_step  <= RST_SAMPLE_STEP;
      load_pos     <= '0;
      load_x       <= '0;
      load_y       <= '0;
      xy_ok        <= 1'b1;
      start_x      <= '0;
      start_y      <= '0;
      start_known  <= 1'b0;
      level        <= '0;
      cnt          <= '0;
      out_valid    <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg_data;
            xy_ok       <= 1'b0;
          end
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_DARK_LEVEL:   dark_level   <= cfg_data[7:0];
          REG_SAMPLE_STEP:  sample_step  <= cfg_data[7:0];
          default: ;
        endcase
      end

      // output register fills from the sequencer, empties on a taken result
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            blue_q  <= chan_blue;
            green_q <= chan_green;
            red_q   <= chan_red;
            dot_q   <= dot_number;
            res_x   <= '0;
            res_y   <= '0;
            unique case (cmd)
              CMD_LOAD: begin
                res_status <= ST_PIXEL;
                if (load_pos >= area) begin
                  state <= S_FIN;
                end else if (!xy_ok) begin
                  rem   <= '0;
                  quo   <= load_pos;
                  cnt   <= '0;
                  state <= S_DIV;
                end else begin
                  state <= S_LOAD;
                end
              end
              CMD_TRACE: begin
                level <= '0;
                cnt   <= '0;
                state <= S_CLR;
              end
              CMD_READ: state <= S_RMUL;
              default: begin
                res_status <= ST_PIXEL;
                state      <= S_FIN;
              end
            endcase
          end
        end

        // position from the load index: one restoring step a cycle
        S_DIV: begin
          if (trial >= w_cl) begin
            rem <= XW'(trial - w_cl);
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= trial[XW-1:0];
            quo <= {quo[PW-2:0], 1'b0};
          end
          cnt <= cnt + MW'(1);
          if (cnt == MW'(PW - 1)) begin
            state <= S_LOAD;
          end
        end

        S_LOAD: begin
          xy_ok <= 1'b1;
          if (is_edge && !start_known) begin
            start_x     <= ld_x;
            start_y     <= ld_y;
            start_known <= 1'b1;
          end
          load_pos <= load_pos + PW'(1);
          if ((XW + 1)'(ld_x) + (XW + 1)'(1) == w_cl) begin
            load_x <= '0;
            load_y <= ld_y + YW'(1);
          end else begin
            load_x <= ld_x + XW'(1);
            load_y <= ld_y;
          end
          state <= S_FIN;
        end

        // clearing pass over the visited map
        S_CLR: begin
          cnt <= cnt + MW'(1);
          if (cnt == '1) begin
            if (!start_known) begin
              res_status <= ST_NONE;
              state      <= S_FIN;
            end else begin
              cur_x <= start_x;
              cur_y <= start_y;
              dir   <= START_DIR;
              tries <= '0;
              state <= S_TRY;
            end
          end
        end

        S_TRY: begin
          if (tries == TRIES_MAX) begin
            state <= S_POP;
          end else if (nbr.at_start) begin
            res_status <= ST_FOUND;
            state      <= S_FIN;
          end else if (nbr.in_image) begin
            nx_q  <= nx;
            ny_q  <= ny;
            state <= S_CHECK;
          end else begin
            dir   <= dir + 3'd1;
            tries <= tries + 4'd1;
          end
        end

        // map data for the latched neighbour is valid here
        S_CHECK: begin
          if (push_ok) begin
            level <= level + LW'(1);
            cur_x <= nx_q[XW-1:0];
            cur_y <= ny_q[YW-1:0];
            dir   <= dir + REVERSE_OFS;
            tries <= '0;
          end else begin
            dir   <= dir + 3'd1;
            tries <= tries + 4'd1;
          end
          state <= S_TRY;
        end

        S_POP: begin
          if (level == '0) begin
            res_status <= ST_NONE;
            state      <= S_FIN;
          end else begin
            level <= level - LW'(1);
            state <= S_POPW;
          end
        end

        S_POPW: begin
          cur_x <= stk_q[EW-1 -: XW];
          cur_y <= stk_q[YW+6 -: YW];
          dir   <= stk_q[6:4];
          tries <= stk_q[3:0];
          state <= S_TRY;
        end

        S_RMUL: begin
          prod  <= 24'(dot_q) * 24'((sample_step == 8'd0) ? 8'd1 : sample_step);
          state <= S_RCHK;
        end

        S_RCHK: begin
          if (32'(prod) < 32'(level)) begin
            state <= S_RDATA;
          end else begin
            res_status <= ST_BEYOND;
            state      <= S_FIN;
          end
        end

        S_RDATA: begin
          res_status <= ST_DOT;
          res_x      <= stk_q[EW-1 -: XW];
          res_y      <= stk_q[YW+6 -: YW];
          state      <= S_FIN;
        end

        // hand the result to the output register once it is free
        S_FIN: begin
          if (fin_fire) begin
            status      <= res_status;
            path_length <= 17'(level);
            dot_x       <= 8'(res_x);
            dot_y       <= 8'(res_y);
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/cct_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the tracer, bound to the top
// depends on cct_pkg for status codes
module cct_checker import cct_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [16:0] path_length,
  input logic [7:0]  dot_x,
  input logic [7:0]  dot_y
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result stays valid and keeps its status and path length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(path_length))
    else $error("stalled result changed");

  // coordinates only with a returned dot
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DOT |-> dot_x == 8'd0 && dot_y == 8'd0)
    else $error("coordinates without dot");

  // a failed trace leaves an empty path
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> path_length == 17'd0)
    else $error("failed trace with path");

  // a returned dot needs a non-empty path
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DOT |-> path_length != 17'd0)
    else $error("dot from empty path");

endmodule

bind closed_contour_tracer_core cct_checker u_cct_checker (.*);
